@@ rtl/core/bdsl_pkg.sv @@
// Package for the button debounce block: register indexes, reset values,
// and the configuration and result structs. Depends on nothing.

package bdsl_pkg;

	// Widths of the configuration port and counters
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;

	// Reset values of the registers
	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CNT_W-1:0] HOLD_RST     = 16'd1000;

	// Settings seen by the timer
	typedef struct packed {
		logic [CNT_W-1:0] debounce_ms;
		logic [CNT_W-1:0] hold_ms;
	} bdsl_cfg_t;

	// One result beat
	typedef struct packed {
		logic short_press;
		logic long_press;
	} bdsl_res_t;

endpackage

@@ rtl/core/bdsl_ifs.sv @@
// Valid/ready channel interfaces for the button debounce block.
// Self-contained; used by the top level.

interface bdsl_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bdsl_out_if;
	logic valid;
	logic ready;
	logic short_press;
	logic long_press;

	modport source (output valid, output short_press, output long_press, input ready);
	modport sink (input valid, input short_press, input long_press, output ready);
endinterface

@@ rtl/core/bdsl_cfg_regs.sv @@
// Configuration registers of the button debounce block.
// Depends on bdsl_pkg.

module bdsl_cfg_regs
	import bdsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output bdsl_cfg_t             cfg
);

	logic [CNT_W-1:0] debounce_q;
	logic [CNT_W-1:0] hold_q;

	// Write decode; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			hold_q     <= HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_wdata[CNT_W-1:0];
				CFG_HOLD:     hold_q     <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.debounce_ms = debounce_q;
	assign cfg.hold_ms     = hold_q;

endmodule

@@ rtl/core/bdsl_timer.sv @@
// Debounce and hold timer: the button state and the step logic that turns
// one tick into a result. Depends on bdsl_pkg.

module bdsl_timer
	import bdsl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      level,
	input  bdsl_cfg_t cfg,
	output bdsl_res_t res
);

	logic             last_level_q;
	logic             running_q;
	logic [CNT_W-1:0] elapsed_q;

	logic             edge_det;
	logic             run_mid;
	logic [CNT_W-1:0] cnt_mid;
	logic             run_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] cnt_inc;
	logic             short_det;
	logic             long_det;

	// Edge handling first, against the count as it stands.
	always_comb begin
		edge_det  = level != last_level_q;
		run_mid   = running_q;
		cnt_mid   = elapsed_q;
		short_det = 1'b0;
		if (edge_det) begin
			if (!running_q) begin
				run_mid = 1'b1;
				cnt_mid = '0;
			end else if (elapsed_q >= cfg.debounce_ms && !level) begin
				short_det = 1'b1;
				cnt_mid   = '0;
			end
		end
	end

	assign cnt_inc = cnt_mid + 1'b1;

	// Then count and compare against debounce and hold.
	always_comb begin
		run_nxt  = run_mid;
		cnt_nxt  = cnt_mid;
		long_det = 1'b0;
		if (run_mid) begin
			cnt_nxt = cnt_inc;
			if (cnt_inc == cfg.debounce_ms && !level) begin
				run_nxt = 1'b0;
			end
			if (cnt_inc == cfg.hold_ms) begin
				run_nxt  = 1'b0;
				long_det = level;
			end
		end
	end

	assign res = {short_det, long_det};

	// State moves only when a tick is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			running_q    <= 1'b0;
			elapsed_q    <= '0;
		end else if (step) begin
			last_level_q <= level;
			running_q    <= run_nxt;
			elapsed_q    <= cnt_nxt;
		end
	end

endmodule

@@ rtl/core/button_debounce_short_long_press_core.sv @@
// Top level of the button debouncer with short and long press detection.
// Depends on bdsl_pkg, bdsl_ifs, bdsl_cfg_regs and bdsl_timer.
//
// Usage: each input beat on in_ch is one millisecond tick carrying the
// sampled button level (1 = pressed). Every tick gives exactly one result
// beat on out_ch with short_press and long_press flags, in tick order.
// Registers are written through cfg_we / cfg_index / cfg_wdata: index 0 is
// the debounce time, index 1 the hold time, both in ticks; write them only
// while no tick is in flight.
// A tick accepted on in_ch sits in the input register, then moves to the
// result register, from which its result beat is taken. Throughput: one
// tick per cycle while out_ch is not stalled, set by the combinational
// compare and increment of the timer.
// Reset clears both pipeline stages and the timer state (button released,
// timer idle) and loads the registers with 50 and 1000.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more tick; in_ch.ready drops only when
// both stages are full.

module button_debounce_short_long_press_core
	import bdsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bdsl_in_if.sink               in_ch,
	bdsl_out_if.source            out_ch
);

	bdsl_cfg_t cfg;
	bdsl_res_t res;
	bdsl_res_t res_q;
	logic      valid_s1;
	logic      level_s1;
	logic      out_valid_q;
	logic      advance;

	bdsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bdsl_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// A tick moves on when the result register is free or being drained.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			level_s1 <= in_ch.pin_level;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.short_press = res_q.short_press;
	assign out_ch.long_press  = res_q.long_press;

	// A release and a held button cannot both be reported on one tick.
	a_press_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.short_press && res_q.long_press))
		else $error("short and long press in the same beat");

	// A tick that cannot move on stays in the input register unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(level_s1)))
		else $error("input stage lost or changed a stalled tick");

	// Input backpressure only when both stages are full and the output stalls.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && out_valid_q && !out_ch.ready))
		else $error("input stalled while the pipeline had room");

endmodule
